// ===== src/tplwm_pkg.sv =====
// shared constants and types for the text pattern line/word matcher
package tplwm_pkg;

  // character codes
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // mode codes
  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_WORD = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31   = 3'd5;

  // pattern storage
  localparam int PAT_LEN_W   = 6;
  localparam int PAT_WORDS   = 4;
  localparam int PAT_CHARS   = 32;
  localparam int PAT_IDX_W   = 7;

  // per-cycle control handed to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== src/tplwm_ifs.sv =====
// request channels: text characters in, verdicts out
interface tplwm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source(output valid, char_in, end_of_input, input ready);
  modport sink(input valid, char_in, end_of_input, output ready);
endinterface

interface tplwm_result_if #(
  parameter int LEN_W = 9
);
  logic             valid;
  logic             ready;
  logic             matched;
  logic [LEN_W-1:0] item_length;
  logic             finished;

  modport source(output valid, matched, item_length, finished, input ready);
  modport sink(input valid, matched, item_length, finished, output ready);
endinterface

// ===== src/tplwm_cell.sv =====
// one window cell: holds a character and its fill bit, compares the incoming one
module tplwm_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  tplwm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]            char_prev,
  input  logic                  valid_prev,
  input  logic [7:0]            pat_char,
  input  logic                  active,
  output logic [7:0]            char_q,
  output logic                  valid_q,
  output logic                  ok
);

  // the value shifting in is the one this cell holds after the step
  assign ok = !active || (valid_prev && (char_prev == pat_char));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl.shift) begin
      valid_q <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      char_q <= char_prev;
    end
  end

endmodule

// ===== src/tplwm_outq.sv =====
// two-entry result queue between the matcher and the result channel
module tplwm_outq #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] q0;
  logic [W-1:0] q1;
  logic [1:0]   cnt;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign space     = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        q0 <= push_data;
      end else begin
        q0 <= q1;
        q1 <= push_data;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        q0 <= push_data;
      end else begin
        q1 <= push_data;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

// ===== src/text_pattern_line_word_matcher.sv =====
// top level of the streaming line substring / one-insertion word matcher
//
// Takes one text character per request and closes lines (mode 0, ended by
// newline, carriage return or end of input) or words (mode 1, ended by
// space, tab, newline or end of input). Every close emits one verdict with
// the item length (saturating at MAX_LINE) and a finished flag that is set
// when an empty item ends the search; after that every terminator gives a
// finished verdict and other characters are dropped. A new character is
// accepted every clock cycle while the result queue has space; a verdict
// is registered into that queue, reaching the result channel in order. The
// rate is set by the window shift: a row of MAX_PATTERN cells moves one
// character per cycle while ordinary characters are accepted and each cell
// compares its incoming character with its pattern byte in that same cycle.
// Results pass through a two-entry queue: input flows while under two verdicts wait.
// Configuration is a plain write port and should be written while idle.
module text_pattern_line_word_matcher #(
  parameter int MAX_PATTERN     = 32,
  parameter int MAX_LINE        = 256,
  parameter int MAX_EXTRA_CHARS = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tplwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tplwm_pkg::CFG_DATA_W-1:0]    cfg_data,
  tplwm_text_if.sink                          text,
  tplwm_result_if.source                      result
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int IW    = tplwm_pkg::PAT_IDX_W;
  localparam int RES_W = CNT_W + 2;

  // configuration registers
  logic                                   mode;
  logic [tplwm_pkg::PAT_LEN_W-1:0]        pattern_length;
  logic [tplwm_pkg::PAT_WORDS-1:0][63:0]  pat_words;
  logic [tplwm_pkg::PAT_CHARS*8-1:0]      pat_bits;

  assign pat_bits = pat_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= tplwm_pkg::MODE_LINE;
      pattern_length <= '0;
      pat_words      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tplwm_pkg::REG_MODE:      mode           <= cfg_data[0];
        tplwm_pkg::REG_PAT_LEN:   pattern_length <= cfg_data[tplwm_pkg::PAT_LEN_W-1:0];
        tplwm_pkg::REG_PAT_0_7:   pat_words[0]   <= cfg_data;
        tplwm_pkg::REG_PAT_8_15:  pat_words[1]   <= cfg_data;
        tplwm_pkg::REG_PAT_16_23: pat_words[2]   <= cfg_data;
        tplwm_pkg::REG_PAT_24_31: pat_words[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pattern byte lookup, bytes past the stored ones read as zero
  function automatic logic [7:0] pat_byte(input logic [IW-1:0] k,
                                          input logic [tplwm_pkg::PAT_CHARS*8-1:0] bits);
    logic [7:0] b;
    b = 8'd0;
    if (k < IW'(tplwm_pkg::PAT_CHARS)) begin
      b = bits[k[4:0]*8 +: 8];
    end
    return b;
  endfunction

  // effective pattern length, capped at the window depth
  logic [IW-1:0]    len_raw;
  logic [LEN_W-1:0] len;

  assign len_raw = IW'(pattern_length);
  assign len = (len_raw > IW'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : LEN_W'(len_raw);

  // per-item state
  logic [CNT_W-1:0] chars_in_item;
  logic             line_hit;
  logic [LEN_W-1:0] matched_prefix;
  logic [1:0]       skip_count;
  logic             search_done;

  // request decode
  logic       accept;
  logic [7:0] c;
  logic       term;
  logic       adv;
  logic       close_item;
  logic       push;
  logic       q_space;

  assign c      = text.char_in;
  assign accept = text.valid && text.ready;
  assign text.ready = q_space;

  always_comb begin
    if (mode == tplwm_pkg::MODE_LINE) begin
      term = text.end_of_input || (c == tplwm_pkg::CHAR_NL) || (c == tplwm_pkg::CHAR_CR);
    end else begin
      term = text.end_of_input || (c == tplwm_pkg::CHAR_SPACE) ||
             (c == tplwm_pkg::CHAR_TAB) || (c == tplwm_pkg::CHAR_NL);
    end
  end

  // adv: ordinary character while searching; close_item: non-empty item ends
  assign adv        = accept && !search_done && !term;
  assign close_item = accept && !search_done && term && (chars_in_item != '0);
  assign push       = accept && term;

  // window: a row of cells, newest character at cell 0
  tplwm_pkg::cell_ctrl_t ctrl;
  logic [7:0] win_char  [MAX_PATTERN];
  logic       win_vld   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;

  assign ctrl.shift = adv;
  assign ctrl.clear = close_item;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0]    char_prev;
    logic          valid_prev;
    logic [IW-1:0] pidx;
    logic          active;

    if (j == 0) begin : g_head
      assign char_prev  = c;
      assign valid_prev = 1'b1;
    end else begin : g_body
      assign char_prev  = win_char[j-1];
      assign valid_prev = win_vld[j-1];
    end

    // cell j holds the character that must equal pattern byte len-1-j
    assign active = IW'(j) < IW'(len);
    assign pidx   = IW'(len) - IW'(1) - IW'(j);

    tplwm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .char_prev  (char_prev),
      .valid_prev (valid_prev),
      .pat_char   (pat_byte(pidx, pat_bits)),
      .active     (active),
      .char_q     (win_char[j]),
      .valid_q    (win_vld[j]),
      .ok         (cell_ok[j])
    );
  end

  logic window_hit;
  assign window_hit = (len != '0) && (&cell_ok);

  // greedy subsequence tracker for word mode
  logic prefix_step;
  assign prefix_step = (matched_prefix < len) &&
                       (c == pat_byte(IW'(matched_prefix), pat_bits));

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_in_item  <= '0;
      line_hit       <= 1'b0;
      matched_prefix <= '0;
      skip_count     <= 2'd0;
      search_done    <= 1'b0;
    end else if (close_item) begin
      chars_in_item  <= '0;
      line_hit       <= 1'b0;
      matched_prefix <= '0;
      skip_count     <= 2'd0;
    end else if (adv) begin
      if (chars_in_item < CNT_W'(MAX_LINE)) begin
        chars_in_item <= chars_in_item + CNT_W'(1);
      end
      if (window_hit) begin
        line_hit <= 1'b1;
      end
      if (prefix_step) begin
        matched_prefix <= matched_prefix + LEN_W'(1);
      end else if (skip_count < 2'd2) begin
        skip_count <= skip_count + 2'd1;
      end
    end else if (push) begin
      // empty item, or any terminator once the search is over
      search_done <= 1'b1;
    end
  end

  // verdict for the item being closed
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] len_x;
  logic             word_ok;
  logic             verdict;

  assign cnt_x   = CMP_W'(chars_in_item);
  assign len_x   = CMP_W'(len);
  assign word_ok = ((cnt_x == len_x) && (skip_count == 2'd0)) ||
                   ((cnt_x == len_x + CMP_W'(MAX_EXTRA_CHARS)) &&
                    (skip_count <= 2'(MAX_EXTRA_CHARS)));
  assign verdict = (mode == tplwm_pkg::MODE_LINE) ? (line_hit || (len == '0)) : word_ok;

  // result packing: matched, length, finished
  logic [RES_W-1:0] push_data;
  logic [RES_W-1:0] head;

  assign push_data = close_item ? {verdict, chars_in_item, 1'b0}
                                : {1'b0, CNT_W'(0), 1'b1};

  tplwm_outq #(
    .W (RES_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (q_space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (head)
  );

  assign result.matched     = head[RES_W-1];
  assign result.item_length = head[CNT_W:1];
  assign result.finished    = head[0];

endmodule

// ===== test/tb.sv =====
// testbench for the text pattern line/word matcher: random and directed text with a scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_PAT         = 32;
  localparam int          MAX_LINE        = 256;
  localparam int          MAX_EXTRA       = 1;
  localparam int          LEN_W           = 9;
  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          PHASES          = 12;
  localparam int          PHASE_ITEMS     = 105;
  localparam logic [7:0]  CHAR_A          = 8'h61;
  localparam logic [7:0]  CHAR_B          = 8'h62;

  // one verdict as it leaves the result channel
  typedef struct packed {
    logic             matched;
    logic [LEN_W-1:0] item_length;
    logic             finished;
  } verdict_t;

  // shadow of the matcher: register copy, both trackers and the verdicts still owed
  class match_scoreboard;
    bit                           mode;
    bit [tplwm_pkg::PAT_LEN_W-1:0] pat_len;
    bit [63:0]                    pat_words [tplwm_pkg::PAT_WORDS];
    bit [7:0]                     recent [MAX_PAT];
    int unsigned                  window_fill;
    int unsigned                  item_chars;
    int unsigned                  prefix;
    int unsigned                  skips;
    bit                           line_hit;
    bit                           done;
    verdict_t                     owed_verdicts [$];
    int unsigned                  errors;

    static function bit closes_item(bit m, bit [7:0] c, bit eoi);
      if (eoi) return 1'b1;
      if (m == tplwm_pkg::MODE_LINE)
        return (c == tplwm_pkg::CHAR_NL) || (c == tplwm_pkg::CHAR_CR);
      return (c == tplwm_pkg::CHAR_SPACE) || (c == tplwm_pkg::CHAR_TAB) ||
             (c == tplwm_pkg::CHAR_NL);
    endfunction

    function void write_reg(logic [tplwm_pkg::CFG_IDX_W-1:0] idx,
                            logic [tplwm_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        tplwm_pkg::REG_MODE:      mode = d[0];
        tplwm_pkg::REG_PAT_LEN:   pat_len = d[tplwm_pkg::PAT_LEN_W-1:0];
        tplwm_pkg::REG_PAT_0_7:   pat_words[0] = d;
        tplwm_pkg::REG_PAT_8_15:  pat_words[1] = d;
        tplwm_pkg::REG_PAT_16_23: pat_words[2] = d;
        tplwm_pkg::REG_PAT_24_31: pat_words[3] = d;
        default: ;
      endcase
    endfunction

    function bit [7:0] pat_byte(int unsigned k);
      if (k >= tplwm_pkg::PAT_CHARS) return 8'h00;
      return pat_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function bit idle();
      return owed_verdicts.size() == 0;
    endfunction

    function void note_char(bit [7:0] c, bit eoi);
      int unsigned eff;
      bit          same;
      bit          m;
      verdict_t    v;
      eff = (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
      if (done) begin
        if (closes_item(mode, c, eoi)) begin
          v = '{matched: 1'b0, item_length: '0, finished: 1'b1};
          owed_verdicts.push_back(v);
        end
        return;
      end
      if (!closes_item(mode, c, eoi)) begin
        if (item_chars < MAX_LINE) item_chars++;
        for (int k = MAX_PAT - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = c;
        if (window_fill < MAX_PAT) window_fill++;
        if (eff > 0 && window_fill >= eff) begin
          same = 1'b1;
          for (int k = 0; k < eff; k++)
            if (recent[eff-1-k] != pat_byte(k)) same = 1'b0;
          if (same) line_hit = 1'b1;
        end
        if (prefix < eff && c == pat_byte(prefix)) prefix++;
        else if (skips < 2) skips++;
        return;
      end
      if (item_chars == 0) begin
        done = 1'b1;
        v = '{matched: 1'b0, item_length: '0, finished: 1'b1};
        owed_verdicts.push_back(v);
        return;
      end
      if (mode == tplwm_pkg::MODE_LINE) m = line_hit || (eff == 0);
      else m = (item_chars == eff && skips == 0) ||
               (item_chars == eff + MAX_EXTRA && skips <= MAX_EXTRA);
      v = '{matched: m, item_length: LEN_W'(item_chars), finished: 1'b0};
      owed_verdicts.push_back(v);
      window_fill = 0;
      item_chars  = 0;
      line_hit    = 1'b0;
      prefix      = 0;
      skips       = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (owed_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %p arrived with none owed", got));
        return;
      end
      want = owed_verdicts.pop_front();
      if (got.matched !== want.matched)
        report_mismatch($sformatf("matched %b, want %b", got.matched, want.matched));
      if (got.item_length !== want.item_length)
        report_mismatch($sformatf("item_length %0d, want %0d",
                                  got.item_length, want.item_length));
      if (got.finished !== want.finished)
        report_mismatch($sformatf("finished %b, want %b", got.finished, want.finished));
    endtask

    task flush_owed();
      while (owed_verdicts.size() != 0)
        report_mismatch($sformatf("verdict %p never arrived", owed_verdicts.pop_front()));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [tplwm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tplwm_pkg::CFG_DATA_W-1:0] cfg_data;

  tplwm_text_if                     text_ch ();
  tplwm_result_if #(.LEN_W(LEN_W))  result_ch ();

  text_pattern_line_word_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text      (text_ch),
    .result    (result_ch)
  );

  always #1 clk = ~clk;

  match_scoreboard sb;

  // stimulus-side view of the text: current terminator set and whether an item is open
  bit          cur_mode;
  bit          item_open;
  bit          allow_empty;
  bit [7:0]    pat [tplwm_pkg::PAT_CHARS];
  int unsigned pat_eff;
  int unsigned phase_items;
  int          send_idle_pct;
  int          recv_stall_pct;

  logic [tplwm_pkg::CFG_IDX_W-1:0] pat_regs [tplwm_pkg::PAT_WORDS] =
    '{tplwm_pkg::REG_PAT_0_7, tplwm_pkg::REG_PAT_8_15,
      tplwm_pkg::REG_PAT_16_23, tplwm_pkg::REG_PAT_24_31};

  // long receiver hold-off: main toggles hold_req, the receiver counts it out
  bit          hold_req  = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // receiver: random stalls, or a solid hold-off after a toggle of hold_req
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen       <= hold_req;
      hold_left       <= HOLD_OFF_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: values sampled here are the ones that held at this edge
  always @(posedge clk) begin
    verdict_t got;
    if (!rst) begin
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        got = '{matched: result_ch.matched, item_length: result_ch.item_length,
                finished: result_ch.finished};
        sb.check_verdict(got);
      end
      if (text_ch.valid === 1'b1 && text_ch.ready === 1'b1)
        sb.note_char(text_ch.char_in, text_ch.end_of_input);
    end
  end

  // watchdog: too many cycles in a row with no request moving on either side
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (text_ch.valid === 1'b1 && text_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one text request, with random idle cycles ahead of it, and wait for acceptance
  task drive_request(bit [7:0] c, bit eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid        <= 1'b1;
    text_ch.char_in      <= c;
    text_ch.end_of_input <= eoi;
    @(posedge clk);
    while (text_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // an empty item sets the sticky done flag, so it is only let through at the end
  task put_char(bit [7:0] c, bit eoi);
    bit [7:0] ch;
    bit       e;
    ch = c;
    e  = eoi;
    if (match_scoreboard::closes_item(cur_mode, ch, e) && !item_open && !allow_empty) begin
      ch = CHAR_A;
      e  = 1'b0;
    end
    item_open = !match_scoreboard::closes_item(cur_mode, ch, e);
    phase_items++;
    drive_request(ch, e);
  endtask

  // terminator of the current mode, or end of input carrying a random byte
  task close_item();
    int r;
    r = $urandom_range(99);
    if (r < 20) put_char(8'($urandom_range(255)), 1'b1);
    else if (cur_mode == tplwm_pkg::MODE_LINE)
      put_char((r < 60) ? tplwm_pkg::CHAR_NL : tplwm_pkg::CHAR_CR, 1'b0);
    else if (r < 47) put_char(tplwm_pkg::CHAR_SPACE, 1'b0);
    else if (r < 74) put_char(tplwm_pkg::CHAR_TAB, 1'b0);
    else put_char(tplwm_pkg::CHAR_NL, 1'b0);
  endtask

  // text byte that does not close an item; biased toward pattern bytes
  function bit [7:0] plain_byte();
    bit [7:0] b;
    int       r;
    do begin
      r = $urandom_range(9);
      if (r < 4 && pat_eff > 0) b = pat[$urandom_range(pat_eff - 1)];
      else if (r < 7) b = (r[0]) ? CHAR_A : CHAR_B;
      else b = 8'($urandom_range(255));
    end while (match_scoreboard::closes_item(cur_mode, b, 1'b0));
    return b;
  endfunction

  // line: random head, the pattern (sometimes with one byte changed, or left out), random tail; or a long random line
  task send_line();
    bit [7:0] q [$];
    int       r;
    int       n;
    int       at;
    r = $urandom_range(99);
    if (r < 3) begin
      n = $urandom_range(250, 300);
      repeat (n) q.push_back(plain_byte());
    end else begin
      n = $urandom_range(8);
      repeat (n) q.push_back(plain_byte());
      if (r < 75 && pat_eff > 0) begin
        at = (r < 55) ? -1 : $urandom_range(pat_eff - 1);
        for (int k = 0; k < pat_eff; k++)
          q.push_back((k == at) ? plain_byte() : pat[k]);
      end
      n = $urandom_range(8);
      repeat (n) q.push_back(plain_byte());
    end
    if (q.size() == 0) q.push_back(plain_byte());
    foreach (q[k]) put_char(q[k], 1'b0);
    close_item();
  endtask

  // word: the pattern exact, with one or two insertions, a deletion, a change, or random
  task send_word();
    bit [7:0] q [$];
    int       r;
    int       n;
    for (int k = 0; k < pat_eff; k++) q.push_back(pat[k]);
    r = $urandom_range(99);
    if (r < 30) begin
    end else if (r < 60) begin
      q.insert($urandom_range(q.size()), plain_byte());
    end else if (r < 70) begin
      if (q.size() > 0) q.delete($urandom_range(q.size() - 1));
    end else if (r < 80) begin
      if (q.size() > 0) q[$urandom_range(q.size() - 1)] = plain_byte();
    end else if (r < 88) begin
      q.insert($urandom_range(q.size()), plain_byte());
      q.insert($urandom_range(q.size()), plain_byte());
    end else begin
      q.delete();
      n = $urandom_range(1, 6);
      repeat (n) q.push_back(plain_byte());
    end
    if (q.size() == 0) q.push_back(plain_byte());
    foreach (q[k]) put_char(q[k], 1'b0);
    close_item();
  endtask

  // raw bytes, terminators and end of input included
  task send_noise();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) put_char(8'($urandom_range(255)), ($urandom_range(7) == 0));
  endtask

  task cfg_write(logic [tplwm_pkg::CFG_IDX_W-1:0] idx, logic [tplwm_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  // new pattern bytes; bytes past the used length are random so every register bit moves
  task pick_pattern(bit m, bit [tplwm_pkg::PAT_LEN_W-1:0] len, bit full_random);
    int unsigned eff;
    int          r;
    bit [7:0]    b;
    eff = (len > MAX_PAT) ? MAX_PAT : len;
    for (int k = 0; k < tplwm_pkg::PAT_CHARS; k++) begin
      if (!full_random && k < eff) begin
        r = $urandom_range(9);
        if (r < 4) b = CHAR_A;
        else if (r < 7) b = CHAR_B;
        else do b = 8'($urandom_range(255));
          while (match_scoreboard::closes_item(m, b, 1'b0));
        pat[k] = b;
      end else begin
        pat[k] = 8'($urandom_range(255));
      end
    end
  endtask

  // all six registers; unused upper bits of mode and length carry random junk
  task load_pattern(bit m, bit [tplwm_pkg::PAT_LEN_W-1:0] len);
    logic [tplwm_pkg::CFG_DATA_W-1:0] d;
    d    = {$urandom, $urandom};
    d[0] = m;
    cfg_write(tplwm_pkg::REG_MODE, d);
    d = {$urandom, $urandom};
    d[tplwm_pkg::PAT_LEN_W-1:0] = len;
    cfg_write(tplwm_pkg::REG_PAT_LEN, d);
    for (int i = 0; i < tplwm_pkg::PAT_WORDS; i++) begin
      for (int k = 0; k < 8; k++) d[k*8 +: 8] = pat[i*8 + k];
      cfg_write(pat_regs[i], d);
    end
    cfg_we   <= 1'b0;
    cur_mode  = m;
    pat_eff   = (len > MAX_PAT) ? MAX_PAT : len;
  endtask

  // stop offering, wait for every owed verdict, then let work in flight settle
  task drain();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (!sb.idle()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    bit [tplwm_pkg::PAT_LEN_W-1:0] len;
    int                            r;
    sb = new;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    text_ch.valid        <= 1'b0;
    text_ch.char_in      <= '0;
    text_ch.end_of_input <= 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct       <= 0;
    cur_mode              = tplwm_pkg::MODE_LINE;
    item_open             = 1'b0;
    allow_empty           = 1'b0;
    pat_eff               = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers: empty pattern, so any line matches
    put_char(CHAR_A, 1'b0);
    put_char(tplwm_pkg::CHAR_NL, 1'b0);
    drain();

    // line mode "ab": zero byte in text, carriage return ends, space is ordinary
    pick_pattern(tplwm_pkg::MODE_LINE, 6'd2, 1'b1);
    pat[0] = CHAR_A;
    pat[1] = CHAR_B;
    load_pattern(tplwm_pkg::MODE_LINE, 6'd2);
    put_char(8'h00, 1'b0);
    put_char(CHAR_A, 1'b0);
    put_char(CHAR_B, 1'b0);
    put_char(tplwm_pkg::CHAR_CR, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(tplwm_pkg::CHAR_SPACE, 1'b0);
    put_char(8'hFF, 1'b1);
    drain();

    // word mode "ab": one insertion, exact, carriage return as the insertion, swapped bytes
    load_pattern(tplwm_pkg::MODE_WORD, 6'd2);
    put_char(CHAR_A, 1'b0);
    put_char(8'h78, 1'b0);
    put_char(CHAR_B, 1'b0);
    put_char(tplwm_pkg::CHAR_TAB, 1'b0);
    put_char(CHAR_A, 1'b0);
    put_char(CHAR_B, 1'b0);
    put_char(tplwm_pkg::CHAR_SPACE, 1'b0);
    put_char(CHAR_A, 1'b0);
    put_char(tplwm_pkg::CHAR_CR, 1'b0);
    put_char(CHAR_B, 1'b0);
    put_char(tplwm_pkg::CHAR_NL, 1'b0);
    put_char(CHAR_B, 1'b0);
    put_char(CHAR_A, 1'b0);
    put_char(tplwm_pkg::CHAR_NL, 1'b0);
    drain();

    // random phases: modes alternate, so an open item sometimes crosses a mode change
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       len = '0;
        1:       len = tplwm_pkg::PAT_LEN_W'(MAX_PAT);
        2:       len = 6'd63;
        3:       len = 6'($urandom_range(63));
        default: len = ($urandom_range(99) < 80) ? 6'($urandom_range(1, 8))
                                                 : 6'($urandom_range(9, 63));
      endcase
      pick_pattern(p[0], len, (p == 3));
      load_pattern(p[0], len);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 53; end
        default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
      endcase
      // receiver goes deaf for a while; sender keeps offering until the block backs up
      if (p == 6) hold_req <= ~hold_req;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 10) send_noise();
        else if (cur_mode == tplwm_pkg::MODE_LINE) send_line();
        else send_word();
      end
      drain();
    end

    // empty line ends the search; afterwards only terminators give verdicts
    send_idle_pct   = 28;
    recv_stall_pct <= 28;
    load_pattern(tplwm_pkg::MODE_LINE, 6'd2);
    put_char(CHAR_A, 1'b0);
    put_char(tplwm_pkg::CHAR_NL, 1'b0);
    allow_empty = 1'b1;
    put_char(tplwm_pkg::CHAR_NL, 1'b0);
    repeat (16) put_char(8'($urandom_range(255)), ($urandom_range(3) == 0));
    put_char(tplwm_pkg::CHAR_CR, 1'b0);
    drain();
    load_pattern(tplwm_pkg::MODE_WORD, 6'd1);
    put_char(CHAR_A, 1'b0);
    put_char(tplwm_pkg::CHAR_SPACE, 1'b0);
    put_char(tplwm_pkg::CHAR_CR, 1'b0);
    put_char(tplwm_pkg::CHAR_TAB, 1'b0);
    put_char(CHAR_A, 1'b1);
    drain();

    repeat (8) @(posedge clk);
    sb.flush_owed();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tplwm_pkg.sv
src/tplwm_ifs.sv
src/tplwm_cell.sv
src/tplwm_outq.sv
src/text_pattern_line_word_matcher.sv
test/tb.sv
